// File: hdl/bsm_pkg.sv
package bsm_pkg;

	localparam int OPND_W          = 8;
	localparam int PROD_W          = 16;
	localparam int CFG_W           = 4;
	localparam int MAX_WIDTH_DEF   = 8;
	localparam logic [CFG_W-1:0] WIDTH_RESET = 4'd8;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} bsm_cmd_t;

	typedef struct packed {
		logic last_step;
	} bsm_sts_t;

endpackage

// File: hdl/booth_signed_multiplier.sv
// Radix-2 Booth multiplier for two's-complement operands of n bits, n taken
// from cfg_wr_data (0 runs as 1, values above MAX_WIDTH clamp to MAX_WIDTH;
// reset value 8). A request is taken when in_valid and in_ready are high; it
// needs a load step, n add-and-shift steps, and a finish step that places
// A:Q in the result register once that register is free; in_ready is low
// until then. The next request may be taken while a result still waits on
// out_ready. Accumulator arithmetic wraps at n bits; the result has zeros
// above bit 2n-1. Write the width register only while idle.
module booth_signed_multiplier
	import bsm_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OPND_W-1:0] multiplicand,
	input  logic [OPND_W-1:0] multiplier,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PROD_W-1:0] product_bits
);

	bsm_cmd_t cmd;
	bsm_sts_t sts;

	bsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bsm_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.multiplicand (multiplicand),
		.multiplier   (multiplier),
		.cmd          (cmd),
		.sts          (sts),
		.product_bits (product_bits)
	);

endmodule

// File: hdl/bsm_ctrl.sv
module bsm_ctrl
	import bsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  bsm_sts_t sts,
	output bsm_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (sts.last_step) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// wait here until the result register can take the product
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/bsm_dp.sv
module bsm_dp
	import bsm_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic [OPND_W-1:0] multiplicand,
	input  logic [OPND_W-1:0] multiplier,
	input  bsm_cmd_t          cmd,
	output bsm_sts_t          sts,
	output logic [PROD_W-1:0] product_bits
);

	localparam int W  = MAX_WIDTH;
	localparam int NW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (W > OPND_W) ? W : OPND_W;
	localparam int PW = (2 * W > PROD_W) ? 2 * W : PROD_W;

	logic [CFG_W-1:0]  width_q;
	logic [NW-1:0]     n_eff;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     cnt_q;
	logic [W-1:0]      a_q;
	logic [W-1:0]      q_q;
	logic              q1_q;
	logic [W-1:0]      m_q;
	logic [PROD_W-1:0] prod_q;

	logic [W-1:0]  eff_sign;
	logic [W-1:0]  eff_mask;
	logic [W-1:0]  sign_vec;
	logic [W-1:0]  mask_vec;
	logic [EW-1:0] m_ext;
	logic [EW-1:0] q_ext;
	logic [W-1:0]  sum;
	logic [W-1:0]  a_next;
	logic [W-1:0]  q_next;
	logic [PW-1:0] wide;

	// width 0 runs as 1, anything above MAX_WIDTH is clamped
	always_comb begin
		if (width_q == '0) begin
			n_eff = NW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			n_eff = NW'(MAX_WIDTH);
		end else begin
			n_eff = NW'(width_q);
		end
	end

	assign eff_sign = W'(1) << (n_eff - NW'(1));
	assign eff_mask = (eff_sign << 1) - W'(1);
	assign sign_vec = W'(1) << (n_q - NW'(1));
	assign mask_vec = (sign_vec << 1) - W'(1);
	assign m_ext    = EW'(multiplicand);
	assign q_ext    = EW'(multiplier);

	always_comb begin
		unique case ({q_q[0], q1_q})
			2'b10:   sum = (a_q - m_q) & mask_vec;
			2'b01:   sum = (a_q + m_q) & mask_vec;
			default: sum = a_q;
		endcase
		a_next = (sum >> 1) | (sum & sign_vec);
		q_next = (q_q >> 1) | (sum[0] ? sign_vec : '0);
	end

	assign wide          = (PW'(a_q) << n_q) | PW'(q_q);
	assign sts.last_step = (cnt_q == '0);
	assign product_bits  = prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_wr_en) begin
			width_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= n_eff;
			cnt_q <= n_eff - NW'(1);
			a_q   <= '0;
			q1_q  <= 1'b0;
			m_q   <= m_ext[W-1:0] & eff_mask;
			q_q   <= q_ext[W-1:0] & eff_mask;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - NW'(1);
			a_q   <= a_next;
			q_q   <= q_next;
			q1_q  <= q_q[0];
		end
		if (cmd.finish) begin
			prod_q <= wide[PROD_W-1:0];
		end
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import bsm_pkg::*;

	localparam int WIDTH_LIMIT = MAX_WIDTH_DEF;
	localparam int REPORT_CAP  = 100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]  cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [OPND_W-1:0] multiplicand = '0;
	logic [OPND_W-1:0] multiplier = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [PROD_W-1:0] product_bits;

	logic [PROD_W-1:0] pending_products[$];
	logic [PROD_W-1:0] expected_product;
	logic [CFG_W-1:0]  width_setting = WIDTH_RESET;
	bit                idle_on = 1'b1;
	int                hold_request = 0;
	int                stall_left = 0;
	int                error_count = 0;

	booth_signed_multiplier #(
		.MAX_WIDTH(WIDTH_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.multiplicand(multiplicand),
		.multiplier(multiplier),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.product_bits(product_bits)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// n Booth steps over A:Q:Q-1, all arithmetic wrapped at n bits
	function automatic logic [PROD_W-1:0] booth_product(input logic [OPND_W-1:0] mcand,
			input logic [OPND_W-1:0] mplier, input logic [CFG_W-1:0] width_reg);
		int                n;
		int                s;
		logic [OPND_W-1:0] mask;
		logic [OPND_W-1:0] sign;
		logic [OPND_W-1:0] mm;
		logic [OPND_W-1:0] acc;
		logic [OPND_W-1:0] mreg;
		logic              trail;
		logic              q0;
		n = int'(width_reg);
		if (n < 1) n = 1;
		if (n > WIDTH_LIMIT) n = WIDTH_LIMIT;
		mask = OPND_W'((32'd1 << n) - 1);
		sign = OPND_W'(32'd1 << (n - 1));
		mm = mcand & mask;
		mreg = mplier & mask;
		acc = '0;
		trail = 1'b0;
		for (s = 0; s < n; s++) begin
			q0 = mreg[0];
			if (q0 && !trail) acc = (acc - mm) & mask;
			else if (!q0 && trail) acc = (acc + mm) & mask;
			trail = q0;
			mreg = ((mreg >> 1) | ({{(OPND_W-1){1'b0}}, acc[0]} << (n - 1))) & mask;
			acc = ((acc >> 1) | (acc & sign)) & mask;
		end
		return PROD_W'((32'(acc) << n) | 32'(mreg));
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= REPORT_CAP)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	// results are checked on the edge where they are taken
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_products.size() == 0) begin
				report_mismatch($sformatf("product %h with no request outstanding",
					product_bits));
			end else begin
				expected_product = pending_products.pop_front();
				if (product_bits !== expected_product)
					report_mismatch($sformatf("product_bits %h, expected %h",
						product_bits, expected_product));
			end
		end
	end

	// receiver: a long hold when asked, otherwise short random stalls while idle_on is set
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_request--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_request(input logic [OPND_W-1:0] mcand, input logic [OPND_W-1:0] mplier);
		in_valid <= 1'b1;
		multiplicand <= mcand;
		multiplier <= mplier;
		do @(posedge clk); while (!in_ready);
		pending_products.push_back(booth_product(mcand, mplier, width_setting));
		// valid stays up for back-to-back requests unless a gap is drawn
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic drain_products();
		in_valid <= 1'b0;
		while (pending_products.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_width(input logic [CFG_W-1:0] value);
		drain_products();
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		width_setting = value;
	endtask

	task automatic send_random(input int count);
		repeat (count) send_request(OPND_W'($urandom_range(0, 255)), OPND_W'($urandom_range(0, 255)));
	endtask

	// reset width of 8: sign extremes, all-ones, alternating multiplier bits
	task automatic test_reset_width();
		send_request(8'h00, 8'h00);
		send_request(8'hFF, 8'hFF);
		send_request(8'h80, 8'h80);
		send_request(8'h80, 8'h7F);
		send_request(8'h7F, 8'h80);
		send_request(8'h7F, 8'h7F);
		send_request(8'h01, 8'h80);
		send_request(8'hB3, 8'hAA);
		send_request(8'h55, 8'h55);
	endtask

	task automatic test_width_zero();
		set_width(4'd0);
		send_request(8'h01, 8'h01);
		send_request(8'hFE, 8'h01);
		send_request(8'hFF, 8'hFE);
	endtask

	task automatic test_width_clamp();
		set_width(4'd15);
		send_request(8'h80, 8'h80);
		send_request(8'hFF, 8'h01);
		set_width(4'd9);
		send_request(8'h7F, 8'hFF);
		send_request(8'hC3, 8'h3C);
	endtask

	// bits above n must have no effect
	task automatic test_unused_bits();
		set_width(4'd4);
		send_request(8'hF8, 8'h58);
		send_request(8'h07, 8'hA7);
		send_request(8'hAF, 8'hF0);
		send_request(8'h5A, 8'hC5);
	endtask

	// output held off long enough that the block stalls its input
	task automatic test_output_backpressure();
		set_width(4'd8);
		hold_request = 150;
		send_random(24);
		drain_products();
	endtask

	task automatic test_random_widths();
		logic [CFG_W-1:0] widths[13];
		int               i;
		widths = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd9, 4'd15, 4'd12, 4'd8};
		for (i = 0; i < 13; i++) begin
			set_width(widths[i]);
			send_random(100);
		end
	endtask

	task automatic test_steady_stream();
		drain_products();
		idle_on = 1'b0;
		set_width(4'd8);
		send_random(100);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_width();
		test_width_zero();
		test_width_clamp();
		test_unused_bits();
		test_output_backpressure();
		test_random_widths();
		test_steady_stream();
		drain_products();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
